// File: rtl/quoted_string_unescape_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quoted string unescape core
// Shared concurrent assertion forms, clocked on i_clk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_STRING_UNESCAPE_CORE_ASSERT_SVH
`define QUOTED_STRING_UNESCAPE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/qsu_pkg.sv
// ----------------------------------------------------------------------------
// Quoted string unescape package
// Item types, decoder modes and character codes shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package qsu_pkg;

    // One raw character of the source string.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_item;

    // One result item.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       done_res;
        logic       status;
    } t_result;

    // Decoder modes.
    typedef enum logic [3:0] {
        MODE_START  = 4'd0,
        MODE_PASS   = 4'd1,
        MODE_BODY   = 4'd2,
        MODE_ESC    = 4'd3,
        MODE_HEX1   = 4'd4,
        MODE_HEX2   = 4'd5,
        MODE_OCT2   = 4'd6,
        MODE_OCT3   = 4'd7,
        MODE_CLOSED = 4'd8,
        MODE_ERROR  = 4'd9
    } t_mode;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Character codes.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;

    // Bytes produced by the simple escapes.
    localparam logic [7:0] BYTE_NUL = 8'd0;
    localparam logic [7:0] BYTE_BEL = 8'd7;
    localparam logic [7:0] BYTE_BS  = 8'd8;
    localparam logic [7:0] BYTE_TAB = 8'd9;
    localparam logic [7:0] BYTE_LF  = 8'd10;
    localparam logic [7:0] BYTE_VT  = 8'd11;
    localparam logic [7:0] BYTE_FF  = 8'd12;
    localparam logic [7:0] BYTE_CR  = 8'd13;

endpackage

`default_nettype wire

// File: rtl/qsu_channels.sv
// ----------------------------------------------------------------------------
// Quoted string unescape channels
// Valid/ready channel interfaces for input characters and result items.
// ----------------------------------------------------------------------------
`default_nettype none

// Input channel: one raw character per item.
interface qsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// Output channel: one result per item.
interface qsu_out_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       done_res;
    logic       status;

    modport source (output valid, output byte_valid, output out_byte,
                    output done_res, output status, input ready);
    modport sink   (input valid, input byte_valid, input out_byte,
                    input done_res, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/quoted_string_unescape_core.sv
// A character accepted is registered in the input stage, then its result in the output stage.
// Throughput: one character per cycle; the only loop is the mode and partial-value register.
// A result held by a stalled output stops the decoder and then the input; no cycles are lost.
// Reset (synchronous, active low) empties both stages and sets the start-of-string mode.
// ----------------------------------------------------------------------------
// Quoted string unescape core
// Decodes C style escapes in a quoted string, one character per item.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_string_unescape_core (
    input  wire       i_clk,
    input  wire       i_rst_n,
    qsu_in_if.sink    i_in,
    qsu_out_if.source o_out
);
    import qsu_pkg::*;

    logic    w_s1_valid;
    t_item   w_s1_item;
    logic    w_out_free;
    logic    w_fire;
    t_result w_res;

    // A registered character is decoded when the output register can take it.
    assign w_fire = w_s1_valid && w_out_free;

    qsu_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_out_free),
        .o_valid (w_s1_valid),
        .o_item  (w_s1_item)
    );

    qsu_decoder u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (w_s1_item),
        .o_res   (w_res)
    );

    qsu_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// File: rtl/qsu_in_stage.sv
// ----------------------------------------------------------------------------
// Quoted string unescape input stage
// Registers each accepted character ahead of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_in_stage (
    input  wire           i_clk,
    input  wire           i_rst_n,
    qsu_in_if.sink        i_in,
    input  wire           i_take,
    output logic          o_valid,
    output qsu_pkg::t_item o_item
);
    import qsu_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;

    // The stage is free when empty or when its item moves on this cycle.
    assign i_in.ready = !r_valid || i_take;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.ch   <= i_in.ch;
            r_item.last <= i_in.last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// File: rtl/qsu_decoder.sv
// ----------------------------------------------------------------------------
// Quoted string unescape decoder
// Mode register and escape decoding for one character per cycle while i_fire is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quoted_string_unescape_core_assert.svh"

module qsu_decoder (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_fire,
    input  qsu_pkg::t_item   i_item,
    output qsu_pkg::t_result o_res
);
    import qsu_pkg::*;

    t_mode      r_mode;
    t_mode      n_mode;
    logic [8:0] r_partial;
    logic [8:0] n_partial;

    t_mode      w_step_mode;
    logic [8:0] w_step_partial;
    logic       w_byte_valid;
    logic [7:0] w_out_byte;

    logic [7:0] w_ch;
    logic       w_is_hex;
    logic [3:0] w_hex_val;
    logic       w_is_simple;
    logic [7:0] w_simple_val;
    logic       w_is_oct;
    logic       w_is_oct_lead;
    logic [8:0] w_oct_sum;

    assign w_ch = i_item.ch;

    // Character classes.
    always_comb begin
        w_is_hex  = 1'b0;
        w_hex_val = 4'd0;
        if (w_ch inside {[CH_ZERO:CH_NINE]}) begin
            w_is_hex  = 1'b1;
            w_hex_val = w_ch[3:0];
        end else if (w_ch inside {[CH_LC_A:CH_LC_F], [CH_UC_A:CH_UC_F]}) begin
            w_is_hex  = 1'b1;
            w_hex_val = 4'(w_ch[3:0] + 4'd9);
        end
    end

    assign w_is_oct      = w_ch inside {[CH_ZERO:CH_SEVEN]};
    assign w_is_oct_lead = w_ch inside {[CH_ONE:CH_SEVEN]};
    assign w_oct_sum     = r_partial + {6'd0, w_ch[2:0]};

    // Simple escape characters.
    always_comb begin
        w_is_simple  = 1'b1;
        w_simple_val = BYTE_NUL;
        case (w_ch)
            CH_ZERO:   w_simple_val = BYTE_NUL;
            CH_LC_N:   w_simple_val = BYTE_LF;
            CH_LC_R:   w_simple_val = BYTE_CR;
            CH_LC_T:   w_simple_val = BYTE_TAB;
            CH_LC_V:   w_simple_val = BYTE_VT;
            CH_LC_A:   w_simple_val = BYTE_BEL;
            CH_LC_B:   w_simple_val = BYTE_BS;
            CH_LC_F:   w_simple_val = BYTE_FF;
            CH_APOS:   w_simple_val = CH_APOS;
            CH_QUOTE:  w_simple_val = CH_QUOTE;
            CH_BSLASH: w_simple_val = CH_BSLASH;
            default:   w_is_simple  = 1'b0;
        endcase
    end

    // Next mode and partial value for this character.
    always_comb begin
        w_step_mode    = r_mode;
        w_step_partial = r_partial;
        case (r_mode)
            MODE_START: begin
                w_step_mode = (w_ch == CH_QUOTE) ? MODE_BODY : MODE_PASS;
            end
            MODE_PASS: begin
                w_step_mode = MODE_PASS;
            end
            MODE_BODY: begin
                if (w_ch == CH_QUOTE) begin
                    w_step_mode = MODE_CLOSED;
                end else if (w_ch == CH_BSLASH) begin
                    w_step_mode = MODE_ESC;
                end
            end
            MODE_ESC: begin
                if (w_is_simple) begin
                    w_step_mode = MODE_BODY;
                end else if (w_ch == CH_X) begin
                    w_step_mode = MODE_HEX1;
                end else if (w_is_oct_lead) begin
                    w_step_partial = {w_ch[2:0], 6'd0};
                    w_step_mode    = MODE_OCT2;
                end else begin
                    w_step_mode = MODE_ERROR;
                end
            end
            MODE_HEX1: begin
                if (w_is_hex) begin
                    w_step_partial = {1'b0, w_hex_val, 4'd0};
                    w_step_mode    = MODE_HEX2;
                end else begin
                    w_step_mode = MODE_ERROR;
                end
            end
            MODE_HEX2: begin
                w_step_mode = w_is_hex ? MODE_BODY : MODE_ERROR;
            end
            MODE_OCT2: begin
                if (w_is_oct) begin
                    w_step_partial = r_partial + {3'd0, w_ch[2:0], 3'd0};
                    w_step_mode    = MODE_OCT3;
                end else begin
                    w_step_mode = MODE_ERROR;
                end
            end
            MODE_OCT3: begin
                if (w_is_oct && !w_oct_sum[8]) begin
                    w_step_mode = MODE_BODY;
                end else begin
                    w_step_mode = MODE_ERROR;
                end
            end
            MODE_CLOSED: begin
                w_step_mode = MODE_CLOSED;
            end
            default: begin
                w_step_mode = MODE_ERROR;
            end
        endcase
    end

    // The end of a string returns the decoder to the start of a string.
    always_comb begin
        if (i_item.last) begin
            n_mode    = MODE_START;
            n_partial = 9'd0;
        end else begin
            n_mode    = w_step_mode;
            n_partial = w_step_partial;
        end
    end

    // Decoded byte for this character.
    always_comb begin
        w_byte_valid = 1'b0;
        w_out_byte   = 8'd0;
        case (r_mode)
            MODE_START: begin
                if (w_ch != CH_QUOTE) begin
                    w_byte_valid = 1'b1;
                    w_out_byte   = w_ch;
                end
            end
            MODE_PASS: begin
                w_byte_valid = 1'b1;
                w_out_byte   = w_ch;
            end
            MODE_BODY: begin
                if (w_ch != CH_QUOTE && w_ch != CH_BSLASH) begin
                    w_byte_valid = 1'b1;
                    w_out_byte   = w_ch;
                end
            end
            MODE_ESC: begin
                if (w_is_simple) begin
                    w_byte_valid = 1'b1;
                    w_out_byte   = w_simple_val;
                end
            end
            MODE_HEX2: begin
                if (w_is_hex) begin
                    w_byte_valid = 1'b1;
                    w_out_byte   = {r_partial[7:4], w_hex_val};
                end
            end
            MODE_OCT3: begin
                if (w_is_oct && !w_oct_sum[8]) begin
                    w_byte_valid = 1'b1;
                    w_out_byte   = w_oct_sum[7:0];
                end
            end
            default: begin
                w_byte_valid = 1'b0;
            end
        endcase
    end

    // Result fields; status only counts on the final character.
    always_comb begin
        o_res.byte_valid = w_byte_valid;
        o_res.out_byte   = w_out_byte;
        o_res.done_res   = i_item.last;
        o_res.status     = STATUS_OK;
        if (i_item.last && w_step_mode != MODE_PASS && w_step_mode != MODE_CLOSED) begin
            o_res.status = STATUS_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_START;
            r_partial <= 9'd0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_partial <= n_partial;
        end
    end

    // Checks on the decoder.
    `QSU_ASSERT_NEXT(a_last_restarts, i_fire && i_item.last, r_mode == MODE_START, "mode not restarted after last item")
    `QSU_ASSERT_NEXT(a_error_sticky, i_fire && !i_item.last && r_mode == MODE_ERROR, r_mode == MODE_ERROR, "error mode left before end of string")
    `QSU_ASSERT_NOW(a_status_on_done, i_fire && !o_res.done_res, o_res.status == STATUS_OK, "status set on an item that is not last")
    `QSU_ASSERT_NOW(a_byte_zero, i_fire && !o_res.byte_valid, o_res.out_byte == 8'd0, "byte nonzero without byte_valid")

endmodule

`default_nettype wire

// File: rtl/qsu_out_stage.sv
// ----------------------------------------------------------------------------
// Quoted string unescape output stage
// Holds each result item until the output channel takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_out_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_load,
    input  qsu_pkg::t_result i_res,
    output logic             o_free,
    qsu_out_if.source        o_out
);
    import qsu_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // A new result may enter when the register is empty or being drained.
    assign o_free = !r_valid || o_out.ready;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.byte_valid = r_res.byte_valid;
    assign o_out.out_byte   = r_res.out_byte;
    assign o_out.done_res   = r_res.done_res;
    assign o_out.status     = r_res.status;

endmodule

`default_nettype wire
